[hdl/pgq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgq_pkg
// Shared types and constants of the pinch gesture qualifier: register
// indexes and reset values, event kinds and the job passed from the front
// part to the back part.
// ----------------------------------------------------------------------------
package pgq_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int TIME_W      = 63;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int RATIO_W     = 16;
  localparam int HOLD_W      = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_HAND_SIDE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTER_RATIO  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_RATIO   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTER_HOLD   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_HOLD    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOST_TIMEOUT = 3'd5;

  localparam logic [RATIO_W-1:0] RST_ENTER_RATIO  = 16'd1229;
  localparam logic [RATIO_W-1:0] RST_EXIT_RATIO   = 16'd1638;
  localparam logic [HOLD_W-1:0]  RST_ENTER_HOLD   = 24'd30000;
  localparam logic [HOLD_W-1:0]  RST_EXIT_HOLD    = 24'd30000;
  localparam logic [HOLD_W-1:0]  RST_LOST_TIMEOUT = 24'd200000;

  typedef enum logic [2:0] {
    EV_PTR_ON  = 3'd0,
    EV_PTR_OFF = 3'd1,
    EV_BEGIN   = 3'd2,
    EV_END     = 3'd3,
    EV_CANCEL  = 3'd4
  } evt_kind_t;

  typedef struct packed {
    logic                          two;
    evt_kind_t                     kind0;
    evt_kind_t                     kind1;
    logic [63:0]                   frame;
    logic [TIME_W-1:0]             time_us;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fifo_status_t;

endpackage
`default_nettype wire

[hdl/pgq_obs_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgq_obs_if
// Observation channel: one hand-tracking observation per beat.
// ----------------------------------------------------------------------------
interface pgq_obs_if;
  logic               valid;
  logic               ready;
  logic               obs_valid;
  logic               obs_hand;
  logic               pointer_on;
  logic               ratio_finite;
  logic [15:0]        pinch_ratio;
  logic [63:0]        frame_number;
  logic signed [63:0] time_us;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (
    output valid, obs_valid, obs_hand, pointer_on, ratio_finite, pinch_ratio,
    output frame_number, time_us, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, obs_valid, obs_hand, pointer_on, ratio_finite, pinch_ratio,
    input  frame_number, time_us, point_x, point_y, point_z,
    output ready
  );
endinterface
`default_nettype wire

[hdl/pgq_evt_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgq_evt_if
// Event channel: one gesture event per beat.
// ----------------------------------------------------------------------------
interface pgq_evt_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [63:0]        event_frame;
  logic [62:0]        event_time_us;
  logic signed [31:0] event_x;
  logic signed [31:0] event_y;
  logic signed [31:0] event_z;
  logic               last_of_run;

  modport source (
    output valid, event_kind, event_frame, event_time_us,
    output event_x, event_y, event_z, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_frame, event_time_us,
    input  event_x, event_y, event_z, last_of_run,
    output ready
  );
endinterface
`default_nettype wire

[hdl/pgq_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgq_front
// Accepts observations, drops stale ones, runs the tracking-loss logic and
// the pinch qualifier, and queues the resulting events as one job.
// ----------------------------------------------------------------------------
module pgq_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pgq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pgq_pkg::CFG_DATA_W-1:0]  cfg_data,
  pgq_obs_if.sink                              obs,
  input  wire logic                            q_full,
  output logic                                 push,
  output pgq_pkg::job_t                        job
);
  import pgq_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_CAND_DOWN = 4'b0010,
    PH_PINCHED   = 4'b0100,
    PH_CAND_UP   = 4'b1000
  } phase_t;

  logic               hand_side;
  logic [RATIO_W-1:0] enter_ratio;
  logic [RATIO_W-1:0] exit_ratio;
  logic [HOLD_W-1:0]  enter_hold;
  logic [HOLD_W-1:0]  exit_hold;
  logic [HOLD_W-1:0]  lost_timeout;

  phase_t                  phase, phase_next;
  logic [TIME_W-1:0]       cand_start, cand_start_next;
  logic [TIME_W-1:0]       lost_start, lost_start_next;
  logic [TIME_W-1:0]       prev_time;
  logic                    have_time;
  logic                    ptr_was_on;
  logic                    gone;
  logic signed [COORD_WIDTH-1:0] saved_x, saved_y, saved_z;

  logic                    accept, drop, lost, commit;
  logic [TIME_W-1:0]       t;
  logic [TIME_W-1:0]       lost_diff, cand_diff;
  logic                    expired, enter_done, exit_done, below, above;
  phase_t                  phase_eff;
  logic                    ev_a, ev_b;
  evt_kind_t               kind_a, kind_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      hand_side    <= 1'b0;
      enter_ratio  <= RST_ENTER_RATIO;
      exit_ratio   <= RST_EXIT_RATIO;
      enter_hold   <= RST_ENTER_HOLD;
      exit_hold    <= RST_EXIT_HOLD;
      lost_timeout <= RST_LOST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HAND_SIDE:    hand_side    <= cfg_data[0];
        CFG_ENTER_RATIO:  enter_ratio  <= cfg_data[RATIO_W-1:0];
        CFG_EXIT_RATIO:   exit_ratio   <= cfg_data[RATIO_W-1:0];
        CFG_ENTER_HOLD:   enter_hold   <= cfg_data[HOLD_W-1:0];
        CFG_EXIT_HOLD:    exit_hold    <= cfg_data[HOLD_W-1:0];
        CFG_LOST_TIMEOUT: lost_timeout <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign obs.ready = !q_full;
  assign accept    = obs.valid && obs.ready;
  assign t         = obs.time_us[TIME_W-1:0];
  assign drop      = obs.time_us[63] || (have_time && t <= prev_time);
  assign lost      = !obs.obs_valid || (obs.obs_hand != hand_side);
  assign commit    = accept && !drop;

  assign lost_diff  = t - lost_start;
  assign cand_diff  = t - cand_start;
  assign expired    = gone ? (lost_diff >= TIME_W'(lost_timeout)) : (lost_timeout == '0);
  assign enter_done = cand_diff >= TIME_W'(enter_hold);
  assign exit_done  = cand_diff >= TIME_W'(exit_hold);
  assign below      = obs.ratio_finite && obs.pinch_ratio <= enter_ratio;
  assign above      = !obs.ratio_finite || obs.pinch_ratio >= exit_ratio;

  always_comb begin
    phase_eff       = phase;
    phase_next      = phase;
    cand_start_next = cand_start;
    lost_start_next = lost_start;
    ev_a            = 1'b0;
    ev_b            = 1'b0;
    kind_a          = EV_PTR_OFF;
    kind_b          = EV_CANCEL;
    if (lost) begin
      ev_a = ptr_was_on;
      if (!gone) begin
        lost_start_next = t;
        case (phase)
          PH_CAND_DOWN: phase_eff = PH_IDLE;
          PH_CAND_UP:   phase_eff = PH_PINCHED;
          default:      phase_eff = phase;
        endcase
      end
      phase_next = phase_eff;
      if (expired) begin
        ev_b       = (phase_eff == PH_PINCHED);
        phase_next = PH_IDLE;
      end
    end else begin
      ev_a   = obs.pointer_on != ptr_was_on;
      kind_a = obs.pointer_on ? EV_PTR_ON : EV_PTR_OFF;
      case (phase)
        PH_IDLE: begin
          if (below) begin
            phase_next      = PH_CAND_DOWN;
            cand_start_next = t;
          end
        end
        PH_CAND_DOWN: begin
          if (!below) begin
            phase_next = PH_IDLE;
          end else if (enter_done) begin
            phase_next = PH_PINCHED;
            ev_b       = 1'b1;
            kind_b     = EV_BEGIN;
          end
        end
        PH_PINCHED: begin
          if (above) begin
            phase_next      = PH_CAND_UP;
            cand_start_next = t;
          end
        end
        default: begin
          if (!above) begin
            phase_next = PH_PINCHED;
          end else if (exit_done) begin
            phase_next = PH_IDLE;
            ev_b       = 1'b1;
            kind_b     = EV_END;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      cand_start <= '0;
      lost_start <= '0;
      prev_time  <= '0;
      have_time  <= 1'b0;
      ptr_was_on <= 1'b0;
      gone       <= 1'b0;
      saved_x    <= '0;
      saved_y    <= '0;
      saved_z    <= '0;
    end else if (commit) begin
      phase      <= phase_next;
      cand_start <= cand_start_next;
      lost_start <= lost_start_next;
      prev_time  <= t;
      have_time  <= 1'b1;
      if (lost) begin
        ptr_was_on <= 1'b0;
        gone       <= 1'b1;
      end else begin
        ptr_was_on <= obs.pointer_on;
        gone       <= 1'b0;
        saved_x    <= obs.point_x[COORD_WIDTH-1:0];
        saved_y    <= obs.point_y[COORD_WIDTH-1:0];
        saved_z    <= obs.point_z[COORD_WIDTH-1:0];
      end
    end
  end

  assign push = commit && (ev_a || ev_b);

  always_comb begin
    job.two     = ev_a && ev_b;
    job.kind0   = ev_a ? kind_a : kind_b;
    job.kind1   = kind_b;
    job.frame   = obs.frame_number;
    job.time_us = t;
    if (lost) begin
      job.x = saved_x;
      job.y = saved_y;
      job.z = saved_z;
    end else begin
      job.x = obs.point_x[COORD_WIDTH-1:0];
      job.y = obs.point_y[COORD_WIDTH-1:0];
      job.z = obs.point_z[COORD_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

[hdl/pgq_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgq_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module pgq_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire pgq_pkg::job_t        wdata,
  input  wire logic                 pop,
  output pgq_pkg::job_t             rdata,
  output pgq_pkg::fifo_status_t     status
);
  import pgq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wrap_inc(wptr);
      end
      if (pop) begin
        rptr <= wrap_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rdata        = entries[rptr];
  assign status.valid = count != '0;
  assign status.full  = count == CNT_W'(QUEUE_DEPTH);

endmodule
`default_nettype wire

[hdl/pgq_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgq_back
// Turns each queued job into one or two event beats through an output
// register.
// ----------------------------------------------------------------------------
module pgq_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pgq_pkg::job_t    head,
  input  wire logic             head_valid,
  output logic                  pop,
  pgq_evt_if.source             evt
);
  import pgq_pkg::*;

  logic                          out_valid;
  logic                          second;
  evt_kind_t                     kind;
  logic [63:0]                   frame;
  logic [TIME_W-1:0]             time_us;
  logic signed [COORD_WIDTH-1:0] x, y, z;
  logic                          last;
  logic                          load, head_last;

  assign load      = !out_valid || evt.ready;
  assign head_last = second || !head.two;
  assign pop       = load && head_valid && head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        second <= !head_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      kind    <= second ? head.kind1 : head.kind0;
      frame   <= head.frame;
      time_us <= head.time_us;
      x       <= head.x;
      y       <= head.y;
      z       <= head.z;
      last    <= head_last;
    end
  end

  assign evt.valid         = out_valid;
  assign evt.event_kind    = kind;
  assign evt.event_frame   = frame;
  assign evt.event_time_us = time_us;
  assign evt.event_x       = 32'(x);
  assign evt.event_y       = 32'(y);
  assign evt.event_z       = 32'(z);
  assign evt.last_of_run   = last;

endmodule
`default_nettype wire

[hdl/pinch_gesture_qualifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pinch_gesture_qualifier
// Qualifies pinch and pointer gestures from a stream of hand observations.
//
//   Channel  Dir  Beat
//   obs      in   one observation (valid, hand, pointer, ratio, frame, time, point)
//   evt      out  one event (kind, frame, time, point, last of run)
//   cfg      in   register write (cfg_we, cfg_index, cfg_data)
//
// An observation is taken whenever the two-entry job queue has room; each
// one yields zero to two events, and the output register sends one event
// per cycle while evt.ready is high.
// Reset is synchronous; it clears control state and restores register defaults.
// A stall on evt backs up the queue and then lowers obs.ready.
// ----------------------------------------------------------------------------
module pinch_gesture_qualifier (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pgq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pgq_pkg::CFG_DATA_W-1:0]  cfg_data,
  pgq_obs_if.sink                              obs,
  pgq_evt_if.source                            evt
);
  import pgq_pkg::*;

  logic         push, pop;
  job_t         wjob, head;
  fifo_status_t qstat;

  pgq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .obs       (obs),
    .q_full    (qstat.full),
    .push      (push),
    .job       (wjob)
  );

  pgq_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (wjob),
    .pop    (pop),
    .rdata  (head),
    .status (qstat)
  );

  pgq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (qstat.valid),
    .pop        (pop),
    .evt        (evt)
  );

`ifndef ASSERT_OFF
  a_second_beat_follows: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready && !evt.last_of_run) |=>
      (evt.valid && evt.event_frame == $past(evt.event_frame)))
    else $error("second event of a run did not follow");

  a_cancel_is_last: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.event_kind == EV_CANCEL) |-> evt.last_of_run)
    else $error("pinch cancel not last of run");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> !qstat.full)
    else $error("job queue overflow");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pinch gesture qualifier. Directed observations
// walk through each pinch phase, pointer edge, loss timeout and dropped
// timestamp. Random gesture sequences then run under several register
// settings and idle patterns. An in-bench model of the qualifier predicts the
// events of every accepted observation, and a monitor compares each event
// beat field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import pgq_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;

  typedef enum logic [1:0] {
    GS_IDLE,
    GS_ARMING,
    GS_HELD,
    GS_RELEASING
  } gesture_phase_t;

  typedef enum int {
    RC_BELOW,
    RC_ABOVE,
    RC_BETWEEN,
    RC_NONFINITE,
    RC_ANY
  } ratio_class_t;

  typedef struct packed {
    logic        valid;
    logic        hand;
    logic        ptr_on;
    logic        finite;
    logic [15:0] ratio;
    logic [63:0] frame;
    logic [63:0] stamp;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } obs_item_t;

  typedef struct packed {
    evt_kind_t   kind;
    logic [63:0] frame;
    logic [62:0] stamp;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        is_last;
  } gesture_event_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pgq_obs_if obs ();
  pgq_evt_if evt ();

  pinch_gesture_qualifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .obs       (obs),
    .evt       (evt)
  );

  logic           tracked_hand;
  logic [15:0]    enter_ratio;
  logic [15:0]    exit_ratio;
  logic [23:0]    enter_hold;
  logic [23:0]    exit_hold;
  logic [23:0]    lost_timeout;
  gesture_phase_t phase;
  logic [63:0]    cand_since;
  logic [63:0]    lost_since;
  logic [63:0]    last_stamp;
  logic           seen_stamp;
  logic           ptr_was_on;
  logic           hand_lost;
  logic [31:0]    seen_x;
  logic [31:0]    seen_y;
  logic [31:0]    seen_z;

  gesture_event_t events_due[$];
  logic [63:0]    stamp_now;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_off_cycles = 0;
  int obs_sent        = 0;
  int obs_dropped     = 0;
  int events_checked  = 0;
  int mismatches      = 0;
  int settings_used   = 1;

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] fix_coord(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int b = COORD_WIDTH; b < 32; b++) begin
      r[b] = v[COORD_WIDTH-1];
    end
    return r;
  endfunction

  function automatic gesture_event_t make_event(input evt_kind_t kind, input obs_item_t o,
                                                input logic [31:0] px, input logic [31:0] py,
                                                input logic [31:0] pz);
    gesture_event_t e;
    e.kind    = kind;
    e.frame   = o.frame;
    e.stamp   = o.stamp[62:0];
    e.x       = px;
    e.y       = py;
    e.z       = pz;
    e.is_last = 1'b0;
    return e;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_HAND_SIDE:    tracked_hand = data[0];
      CFG_ENTER_RATIO:  enter_ratio  = data[15:0];
      CFG_EXIT_RATIO:   exit_ratio   = data[15:0];
      CFG_ENTER_HOLD:   enter_hold   = data[23:0];
      CFG_EXIT_HOLD:    exit_hold    = data[23:0];
      CFG_LOST_TIMEOUT: lost_timeout = data[23:0];
      default: ;
    endcase
  endfunction

  // Works out the events of one accepted observation and queues them.
  task automatic qualify_obs(input obs_item_t o);
    gesture_event_t caused[$];
    gesture_event_t ev;
    logic [31:0]    px;
    logic [31:0]    py;
    logic [31:0]    pz;
    logic           below;
    logic           above;
    if (o.stamp[63] || (seen_stamp && o.stamp <= last_stamp)) begin
      obs_dropped++;
      return;
    end
    last_stamp = o.stamp;
    seen_stamp = 1'b1;
    if (!o.valid || o.hand != tracked_hand) begin
      if (ptr_was_on) begin
        caused.push_back(make_event(EV_PTR_OFF, o, seen_x, seen_y, seen_z));
        ptr_was_on = 1'b0;
      end
      if (!hand_lost) begin
        hand_lost  = 1'b1;
        lost_since = o.stamp;
        if (phase == GS_ARMING) begin
          phase = GS_IDLE;
        end else if (phase == GS_RELEASING) begin
          phase = GS_HELD;
        end
      end
      if (o.stamp - lost_since >= {40'd0, lost_timeout}) begin
        if (phase == GS_HELD) begin
          caused.push_back(make_event(EV_CANCEL, o, seen_x, seen_y, seen_z));
        end
        phase = GS_IDLE;
      end
    end else begin
      px = fix_coord(o.x);
      py = fix_coord(o.y);
      pz = fix_coord(o.z);
      hand_lost = 1'b0;
      seen_x = px;
      seen_y = py;
      seen_z = pz;
      if (o.ptr_on && !ptr_was_on) begin
        caused.push_back(make_event(EV_PTR_ON, o, px, py, pz));
      end else if (!o.ptr_on && ptr_was_on) begin
        caused.push_back(make_event(EV_PTR_OFF, o, px, py, pz));
      end
      ptr_was_on = o.ptr_on;
      below = o.finite && o.ratio <= enter_ratio;
      above = !o.finite || o.ratio >= exit_ratio;
      case (phase)
        GS_IDLE: begin
          if (below) begin
            phase      = GS_ARMING;
            cand_since = o.stamp;
          end
        end
        GS_ARMING: begin
          if (!below) begin
            phase = GS_IDLE;
          end else if (o.stamp - cand_since >= {40'd0, enter_hold}) begin
            phase = GS_HELD;
            caused.push_back(make_event(EV_BEGIN, o, px, py, pz));
          end
        end
        GS_HELD: begin
          if (above) begin
            phase      = GS_RELEASING;
            cand_since = o.stamp;
          end
        end
        default: begin
          if (!above) begin
            phase = GS_HELD;
          end else if (o.stamp - cand_since >= {40'd0, exit_hold}) begin
            phase = GS_IDLE;
            caused.push_back(make_event(EV_END, o, px, py, pz));
          end
        end
      endcase
    end
    foreach (caused[i]) begin
      ev = caused[i];
      ev.is_last = (i == caused.size() - 1);
      events_due.push_back(ev);
    end
  endtask

  task automatic send_obs(input obs_item_t o);
    if ($urandom_range(99) < send_idle_pct) begin
      obs.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    obs.valid        <= 1'b1;
    obs.obs_valid    <= o.valid;
    obs.obs_hand     <= o.hand;
    obs.pointer_on   <= o.ptr_on;
    obs.ratio_finite <= o.finite;
    obs.pinch_ratio  <= o.ratio;
    obs.frame_number <= o.frame;
    obs.time_us      <= o.stamp;
    obs.point_x      <= o.x;
    obs.point_y      <= o.y;
    obs.point_z      <= o.z;
    @(posedge clk);
    while (!obs.ready) @(posedge clk);
    qualify_obs(o);
    obs_sent++;
  endtask

  function automatic obs_item_t random_obs();
    obs_item_t o;
    o.valid  = 1'($urandom_range(1));
    o.hand   = 1'($urandom_range(1));
    o.ptr_on = 1'($urandom_range(1));
    o.finite = 1'($urandom_range(1));
    o.ratio  = 16'($urandom);
    o.frame  = rand64();
    o.stamp  = rand64();
    o.x      = $urandom;
    o.y      = $urandom;
    o.z      = $urandom;
    return o;
  endfunction

  function automatic logic [15:0] pick_ratio(input ratio_class_t rc);
    case (rc)
      RC_BELOW:   return 16'($urandom_range(enter_ratio, 0));
      RC_ABOVE:   return 16'($urandom_range(65535, exit_ratio));
      RC_BETWEEN: return 16'($urandom_range(exit_ratio, enter_ratio));
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] next_step();
    int unsigned cap;
    int unsigned tmo;
    cap = 32'(enter_hold > exit_hold ? enter_hold : exit_hold);
    cap = cap / 2 + 2;
    tmo = 32'(lost_timeout);
    case ($urandom_range(9))
      0, 1:    return 64'($urandom_range(50, 1));
      2:       return 64'($urandom_range(tmo + 1000, tmo / 2 + 1));
      default: return 64'($urandom_range(cap, 1));
    endcase
  endfunction

  task automatic offer_obs(input logic valid, input logic hand, input logic ptr,
                           input ratio_class_t rc);
    obs_item_t o;
    o = random_obs();
    stamp_now = stamp_now + next_step();
    o.valid   = valid;
    o.hand    = hand;
    o.ptr_on  = ptr;
    if (rc == RC_NONFINITE) begin
      o.finite = 1'b0;
    end else if (rc != RC_ANY) begin
      o.finite = 1'b1;
    end
    o.ratio = pick_ratio(rc);
    o.stamp = stamp_now;
    send_obs(o);
  endtask

  task automatic offer_stale();
    obs_item_t o;
    o = random_obs();
    case ($urandom_range(2))
      0:       o.stamp = stamp_now;
      1:       o.stamp = stamp_now - 64'($urandom_range(1000, 1));
      default: o.stamp[63] = 1'b1;
    endcase
    send_obs(o);
  endtask

  task automatic offer_exact(input logic [63:0] stamp, input logic valid, input logic hand,
                             input logic ptr, input logic finite, input logic [15:0] ratio,
                             input logic [63:0] frame, input logic [31:0] x);
    obs_item_t o;
    o = random_obs();
    o.stamp  = stamp;
    o.valid  = valid;
    o.hand   = hand;
    o.ptr_on = ptr;
    o.finite = finite;
    o.ratio  = ratio;
    o.frame  = frame;
    o.x      = x;
    o.y      = ~x;
    send_obs(o);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Narrow registers get random upper bits, and each setting ends with a
  // write to an index past the register list.
  task automatic load_setting(input logic hand, input logic [15:0] en, input logic [15:0] ex,
                              input logic [23:0] eh, input logic [23:0] xh,
                              input logic [23:0] tmo);
    write_reg(CFG_HAND_SIDE, {23'($urandom), hand});
    write_reg(CFG_ENTER_RATIO, {8'($urandom), en});
    write_reg(CFG_EXIT_RATIO, {8'($urandom), ex});
    write_reg(CFG_ENTER_HOLD, eh);
    write_reg(CFG_EXIT_HOLD, xh);
    write_reg(CFG_LOST_TIMEOUT, tmo);
    write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_setting();
    logic [15:0] en;
    logic [15:0] ex;
    en = 16'($urandom_range(3000, 400));
    ex = en + 16'($urandom_range(1500, 0));
    load_setting(1'($urandom_range(1)), en, ex, 24'($urandom_range(60000, 0)),
                 24'($urandom_range(60000, 0)), 24'($urandom_range(300000, 0)));
  endtask

  task automatic drain_events();
    int waited;
    waited = 0;
    obs.valid <= 1'b0;
    while (events_due.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (events_due.size() > 0) begin
      $display("%0t: %0d expected events never arrived", $time, events_due.size());
      mismatches += events_due.size();
      events_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly runs of frames for the tracked hand with one ratio class, so that
  // the phases advance, mixed with tracking loss, noise and stale stamps.
  task automatic gesture_traffic(input int count);
    int           done_cnt;
    int           seg;
    int           k;
    int           pick;
    logic         ptr;
    ratio_class_t rc;
    done_cnt = 0;
    ptr = 1'($urandom_range(1));
    while (done_cnt < count) begin
      seg = $urandom_range(99);
      if (seg < 5) begin
        offer_stale();
      end else if (seg < 20) begin
        k = $urandom_range(4, 1);
        repeat (k) begin
          if ($urandom_range(1)) begin
            offer_obs(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), RC_ANY);
          end else begin
            offer_obs(1'b1, ~tracked_hand, 1'($urandom_range(1)), RC_ANY);
          end
        end
        done_cnt += k;
      end else if (seg < 28) begin
        offer_obs(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), RC_ANY);
        done_cnt++;
      end else begin
        pick = $urandom_range(99);
        rc = pick < 40 ? RC_BELOW : pick < 65 ? RC_ABOVE : pick < 85 ? RC_BETWEEN : RC_NONFINITE;
        k = $urandom_range(6, 2);
        repeat (k) begin
          if ($urandom_range(99) < 25) begin
            ptr = ~ptr;
          end
          offer_obs(1'b1, tracked_hand, ptr, rc);
        end
        done_cnt += k;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_event();
    gesture_event_t want;
    if (events_due.size() == 0) begin
      $display("%0t: unexpected event, expected none, actual kind %0d frame %h time %h",
               $time, evt.event_kind, evt.event_frame, evt.event_time_us);
      mismatches++;
      return;
    end
    want = events_due.pop_front();
    events_checked++;
    compare_field("kind", 64'(want.kind), 64'(evt.event_kind));
    compare_field("frame", want.frame, evt.event_frame);
    compare_field("time", 64'(want.stamp), 64'(evt.event_time_us));
    compare_field("x", 64'(want.x), 64'($unsigned(evt.event_x)));
    compare_field("y", 64'(want.y), 64'($unsigned(evt.event_y)));
    compare_field("z", 64'(want.z), 64'($unsigned(evt.event_z)));
    compare_field("last_of_run", 64'(want.is_last), 64'(evt.last_of_run));
  endtask

  initial begin
    evt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && evt.valid && evt.ready) begin
        check_event();
      end
      if (hold_off_cycles > 0) begin
        evt.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        evt.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic test_directed_cases();
    offer_exact(64'd0, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 64'd0, 32'hFFFF_FFFF);
    offer_exact(64'd0, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd10, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    offer_exact(64'd30010, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1229, rand64(), 32'h0);
    offer_exact(64'd40000, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, rand64(), $urandom);
    offer_exact(64'd50000, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd249999, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd250000, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd260000, 1'b1, 1'b0, 1'b1, 1'b1, 16'hFFFF, rand64(), 32'h7FFF_FFFF);
    offer_exact(64'd270000, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1230, rand64(), $urandom);
    offer_exact(64'd280000, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1229, rand64(), $urandom);
    offer_exact(64'd290000, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1230, rand64(), $urandom);
    offer_exact(64'd300000, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd310000, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd900000, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, rand64(), $urandom);
    offer_exact(64'd900001, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd930001, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'd930002, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1638, rand64(), $urandom);
    offer_exact(64'd930003, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1637, rand64(), $urandom);
    offer_exact(64'd940000, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, rand64(), $urandom);
    offer_exact(64'd970000, 1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF, rand64(), $urandom);
    stamp_now = 64'd970000;
  endtask

  task automatic test_register_extremes();
    drain_events();
    load_setting(1'b1, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0);
    gesture_traffic(50);
    drain_events();
    load_setting(1'b0, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    gesture_traffic(50);
    drain_events();
    load_setting(1'b1, 16'hFFFF, 16'd0, 24'd0, 24'hFF_FFFF, 24'd0);
    gesture_traffic(50);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      drain_events();
      random_setting();
      gesture_traffic(150);
    end
  endtask

  task automatic test_steady_stream();
    run_random_phase(0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(53, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(0, 53);
  endtask

  task automatic test_mixed_idling();
    run_random_phase(38, 38);
  endtask

  // The receiver holds off while pointer edges keep coming, so the job queue
  // fills and the observation channel stalls; the sender then waits for all
  // events before going on.
  task automatic test_backpressure();
    logic ptr;
    drain_events();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_setting();
    ptr = 1'b0;
    hold_off_cycles = 200;
    repeat (40) begin
      ptr = ~ptr;
      offer_obs(1'b1, tracked_hand, ptr, RC_ANY);
    end
    drain_events();
    recv_stall_pct = 53;
    gesture_traffic(20);
  endtask

  task automatic test_large_timestamps();
    drain_events();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    random_setting();
    stamp_now = {2'b01, 62'(rand64())};
    gesture_traffic(12);
    stamp_now = 64'h7FFF_FFFF_FF00_0000;
    gesture_traffic(10);
    offer_exact(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, tracked_hand, 1'b1, 1'b1, 16'd0, rand64(), $urandom);
    offer_exact(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, tracked_hand, 1'b0, 1'b0, 16'd0, rand64(), $urandom);
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_HAND_SIDE;
    cfg_data         <= '0;
    obs.valid        <= 1'b0;
    obs.obs_valid    <= 1'b0;
    obs.obs_hand     <= 1'b0;
    obs.pointer_on   <= 1'b0;
    obs.ratio_finite <= 1'b0;
    obs.pinch_ratio  <= '0;
    obs.frame_number <= '0;
    obs.time_us      <= '0;
    obs.point_x      <= '0;
    obs.point_y      <= '0;
    obs.point_z      <= '0;
    tracked_hand = 1'b0;
    enter_ratio  = RST_ENTER_RATIO;
    exit_ratio   = RST_EXIT_RATIO;
    enter_hold   = RST_ENTER_HOLD;
    exit_hold    = RST_EXIT_HOLD;
    lost_timeout = RST_LOST_TIMEOUT;
    phase        = GS_IDLE;
    cand_since   = '0;
    lost_since   = '0;
    last_stamp   = '0;
    seen_stamp   = 1'b0;
    ptr_was_on   = 1'b0;
    hand_lost    = 1'b0;
    seen_x       = '0;
    seen_y       = '0;
    seen_z       = '0;
    stamp_now    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure();
    test_large_timestamps();
    drain_events();
    $display("Sent %0d observations, %0d of them with stale or negative stamps.",
             obs_sent, obs_dropped);
    $display("Checked %0d events under %0d register settings, extremes and idling included.",
             events_checked, settings_used);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hdl/pgq_pkg.sv
hdl/pgq_obs_if.sv
hdl/pgq_evt_if.sv
hdl/pgq_front.sv
hdl/pgq_fifo.sv
hdl/pgq_back.sv
hdl/pinch_gesture_qualifier.sv
sim/testbench.sv
